// ===== design/assert_macros.svh =====
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/ffsa_pkg.sv =====
// shared types and constants of the first-fit spectrum allocator
`timescale 1ns / 1ps

package ffsa_pkg;

    localparam int SLOTS_DEF = 128;
    localparam int LINKS_DEF = 64;

    // divider operand widths: numerator is demand + cores - 1
    localparam int NUMER_W = 14;
    localparam int DENOM_W = 6;
    // window width before range check: quotient + guard
    localparam int CALC_W  = 15;

    typedef enum logic [0:0] {
        CFG_CORE_COUNT  = 1'b0,
        CFG_GUARD_SLOTS = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [63:0] link_mask;
        logic [12:0] slots_needed;
        logic [6:0]  release_first;
        logic [6:0]  release_last;
    } in_item_t;

    typedef struct packed {
        logic       granted;
        logic [6:0] first_slot;
        logic [6:0] last_slot;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [NUMER_W-1:0] numer;
        logic [DENOM_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [NUMER_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== design/first_fit_spectrum_allocator.sv =====
// top level of the first-fit spectrum allocator
// channels: in_valid/in_ready/in_item takes one allocate or release item,
// out_valid/out_ready/out_item returns exactly one result item for each.
// cfg_we/cfg_index/cfg_data writes core_count (index 0) or guard_slots
// (index 1); write only while no item is in flight.
// one item at a time; only mask bits below LINKS name path links.
// steps from the accepting edge to out_valid:
//   allocate: occupancy read sweep, window check, fit search, start pick,
//     write sweep and done; the window divider runs beside the occupancy
//     read sweep; a window too wide for the spectrum skips the fit search
//     and the write sweep, a request with no fitting window skips the
//     write sweep
//   release: write sweep and done
//   with an empty mask the sweeps access no ram entry
// a new item is taken once its result is registered.
// the sweeps read each path link once; the write sweep also writes it back.
// reset clears all link bitmaps at once through per-link valid bits and sets
// core_count to 7 and guard_slots to 1; no clearing pass is needed.
// the result sits in an output register; the next item is taken while it
// waits, and a stalled receiver only holds the block in its final step.

`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_spectrum_allocator #(
    parameter int SLOTS = ffsa_pkg::SLOTS_DEF,
    parameter int LINKS = ffsa_pkg::LINKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffsa_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ffsa_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [5:0]          cfg_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int WB     = $clog2(SLOTS + 1);       // bits of a window width
    localparam int KW     = $clog2(WB);
    localparam int IW     = (SLOT_W > 7) ? SLOT_W : 7;
    localparam int CALC_W = ffsa_pkg::CALC_W;

    // one-hot sequencer
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,   // or the path bitmaps, divider runs alongside
        S_CHK  = 7'b0000100,   // window width and range check
        S_FIT  = 7'b0001000,   // free-run doubling, one width bit per cycle
        S_PICK = 7'b0010000,   // lowest fitting start
        S_WR   = 7'b0100000,   // read-modify-write sweep over path links
        S_DONE = 7'b1000000
    } state_t;

    function automatic logic [LINK_W-1:0] low_link(input logic [LINKS-1:0] v);
        logic [LINK_W-1:0] r;
        r = '0;
        for (int i = LINKS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = LINK_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] low_slot(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // bits lo..hi set; bits past the spectrum simply do not exist
    function automatic logic [SLOTS-1:0] range_mask(input logic [IW-1:0] lo,
                                                    input logic [IW-1:0] hi);
        logic [SLOTS-1:0] m;
        for (int s = 0; s < SLOTS; s++)
        begin
            m[s] = (IW'(s) >= lo) && (IW'(s) <= hi);
        end
        return m;
    endfunction

    // configuration
    logic [5:0] core_count_reg;
    logic [3:0] guard_reg;

    // control
    state_t              state_reg, state_next;
    logic [LINKS-1:0]    rem_reg, rem_next;        // links still to sweep
    logic [LINKS-1:0]    mask_reg, mask_next;      // path links of the item
    logic                pend_reg, pend_next;      // ram read in flight
    logic [LINK_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                op_rel_reg, op_rel_next;
    logic                out_valid_reg, out_valid_next;
    logic [LINKS-1:0]    vld_reg, vld_next;        // link bitmap written since reset
    logic                rd_vld_reg;
    logic [KW-1:0]       k_reg, k_next;

    // datapath
    logic [SLOTS-1:0]    acc_reg, acc_next;        // or of path bitmaps
    logic [SLOTS-1:0]    g_reg, g_next;            // starts with a free run of len
    logic [SLOTS-1:0]    p_reg, p_next;            // starts with a free run of 2^k
    logic [WB-1:0]       len_reg, len_next;
    logic [WB-1:0]       width_reg, width_next;
    logic [SLOTS-1:0]    win_reg, win_next;
    ffsa_pkg::out_item_t res_reg, res_next;
    ffsa_pkg::out_item_t out_reg, out_next;

    // ram and divider hookup
    logic                ram_we, ram_re;
    logic [LINK_W-1:0]   ram_waddr, ram_raddr;
    logic [SLOTS-1:0]    ram_wdata, ram_rdata, rd_word;
    ffsa_pkg::div_req_t  div_req;
    ffsa_pkg::div_rsp_t  div_rsp;

    logic                accept;
    logic [5:0]          cores;
    logic [CALC_W-1:0]   win_width;
    logic [WB-1:0]       pow_k;
    logic [SLOT_W-1:0]   start_slot;
    logic [SLOT_W-1:0]   end_slot;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign cores    = (core_count_reg == 6'd0) ? 6'd1 : core_count_reg;

    // ceil(demand / cores) from the divider
    assign div_req.start = accept && (in_item.func == ffsa_pkg::FUNC_ALLOC);
    assign div_req.numer = ffsa_pkg::NUMER_W'(in_item.slots_needed)
                         + ffsa_pkg::NUMER_W'(cores) - ffsa_pkg::NUMER_W'(1);
    assign div_req.denom = cores;

    assign win_width  = CALC_W'(div_rsp.quot) + CALC_W'(guard_reg);
    assign pow_k      = WB'(1) << k_reg;
    assign start_slot = low_slot(g_reg);
    assign end_slot   = SLOT_W'(WB'(start_slot) + width_reg - WB'(1));

    // sweep: one read issued per cycle, its data used the cycle after
    assign ram_re    = ((state_reg == S_RD) || (state_reg == S_WR)) && (|rem_reg);
    assign ram_raddr = low_link(rem_reg);
    assign rd_word   = rd_vld_reg ? ram_rdata : '0;
    assign ram_we    = (state_reg == S_WR) && pend_reg;
    assign ram_waddr = pend_addr_reg;
    assign ram_wdata = op_rel_reg ? (rd_word & ~win_reg) : (rd_word | win_reg);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        mask_next      = mask_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        op_rel_next    = op_rel_reg;
        out_valid_next = out_valid_reg;
        vld_next       = vld_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        g_next         = g_reg;
        p_next         = p_reg;
        len_next       = len_reg;
        width_next     = width_reg;
        win_next       = win_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ram_re)
        begin
            rem_next       = rem_reg & ~(LINKS'(1) << ram_raddr);
            pend_next      = 1'b1;
            pend_addr_next = ram_raddr;
        end
        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rem_next  = in_item.link_mask[LINKS-1:0];
                    mask_next = in_item.link_mask[LINKS-1:0];
                    acc_next  = '0;
                    if (in_item.func == ffsa_pkg::FUNC_RELEASE)
                    begin
                        op_rel_next         = 1'b1;
                        win_next            = range_mask(IW'(in_item.release_first),
                                                         IW'(in_item.release_last));
                        res_next.granted    = 1'b1;
                        res_next.first_slot = in_item.release_first;
                        res_next.last_slot  = in_item.release_last;
                        state_next          = S_WR;
                    end
                    else
                    begin
                        op_rel_next = 1'b0;
                        res_next    = '0;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_reg | rd_word;
                end
                if (!(|rem_reg) && !pend_reg && div_rsp.done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // zero width and windows wider than the spectrum are blocked
                if ((win_width == '0) || (win_width > CALC_W'(SLOTS)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    width_next = win_width[WB-1:0];
                    g_next     = '1;
                    p_next     = ~acc_reg;
                    len_next   = '0;
                    k_next     = '0;
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                // zeros shifted in past the top act as busy slots
                if (width_reg[k_reg])
                begin
                    g_next   = g_reg & (p_reg >> len_reg);
                    len_next = len_reg + pow_k;
                end
                p_next = p_reg & (p_reg >> pow_k);
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(WB - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!(|g_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    win_next            = range_mask(IW'(start_slot), IW'(end_slot));
                    res_next.granted    = 1'b1;
                    res_next.first_slot = 7'(start_slot);
                    res_next.last_slot  = 7'(end_slot);
                    rem_next            = mask_reg;
                    state_next          = S_WR;
                end
            end
            S_WR:
            begin
                if (!(|rem_reg) && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rem_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            vld_reg        <= '0;
            k_reg          <= '0;
            core_count_reg <= 6'd7;
            guard_reg      <= 4'd1;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            k_reg         <= k_next;
            if (cfg_we)
            begin
                unique case (ffsa_pkg::cfg_idx_t'(cfg_index))
                    ffsa_pkg::CFG_CORE_COUNT:  core_count_reg <= cfg_data;
                    ffsa_pkg::CFG_GUARD_SLOTS: guard_reg      <= cfg_data[3:0];
                    default:                   core_count_reg <= core_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg      <= mask_next;
        pend_addr_reg <= pend_addr_next;
        op_rel_reg    <= op_rel_next;
        acc_reg       <= acc_next;
        g_reg         <= g_next;
        p_reg         <= p_next;
        len_reg       <= len_next;
        width_reg     <= width_next;
        win_reg       <= win_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    ffsa_ram #(
        .WIDTH (SLOTS),
        .DEPTH (LINKS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // the write sweep trails the read by one link, never the same entry
    `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    // only links on the path are ever written
    `ASSERT_IMPLIES(a_write_on_path, clk, rst_n, ram_we, mask_reg[ram_waddr])
    // the fit search only runs on a window that fits the spectrum
    `ASSERT_IMPLIES(a_fit_width, clk, rst_n, state_reg == S_FIT,
                    (width_reg != '0) && (width_reg <= WB'(SLOTS)))
    // a waiting result is never overwritten
    `ASSERT_NEXT(a_done_holds, clk, rst_n,
                 (state_reg == S_DONE) && out_valid_reg && !out_ready,
                 state_reg == S_DONE)

endmodule

// ===== design/ffsa_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffsa_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ffsa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ffsa_pkg::div_req_t req,
    output ffsa_pkg::div_rsp_t rsp
);

    localparam int NW = ffsa_pkg::NUMER_W;
    localparam int DW = ffsa_pkg::DENOM_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quot_reg, quot_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quot_reg[NW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = req.numer;
            den_next  = req.denom;
        end
        else if (busy_reg)
        begin
            // shift numerator bits out of the top, quotient bits in at the bottom
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = DW'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DW-1:0];
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = !busy_reg;
    assign rsp.quot = quot_reg;

endmodule
